// ===== src/shared_buffer_multi_stack_defines.svh =====
// Assertion macros shared by the modules of the multi-stack buffer.
`ifndef SHARED_BUFFER_MULTI_STACK_DEFINES_SVH
`define SHARED_BUFFER_MULTI_STACK_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBMS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("shared buffer multi stack: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SBMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("shared buffer multi stack: assertion failed");

`endif

// ===== src/sbms_pkg.sv =====
package sbms_pkg;

    typedef enum logic {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic commit;
    } t_cmd;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned SID_W   = 2;

    localparam logic signed [VALUE_W-1:0] POP_EMPTY_VALUE = '1;
    localparam logic signed [VALUE_W-1:0] PUSH_VALUE      = '0;

endpackage

// ===== src/shared_buffer_multi_stack.sv =====
// Channel   Handshake                  Payload
// input     i_in_valid / o_in_stall    i_kind, i_stack_id, i_value
// output    o_out_valid / i_out_stall  o_status, o_popped
//
// Each transaction is a registered read of the entry store and the stack top, followed by
// the write-back of links, pointers and the result register.
// The next transaction is taken once the write-back is done, since it depends on it.
// Reset is synchronous; unused entries are tracked by a fill mark,
// so there is no clearing pass over the store.
// While the result register is full and stalled, the write-back waits and input stays stalled until it is done.
module shared_buffer_multi_stack #(
    parameter int NUM_STACKS = 4,
    parameter int DEPTH      = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_kind,
    input  logic [sbms_pkg::SID_W-1:0]            i_stack_id,
    input  logic signed [sbms_pkg::VALUE_W-1:0]   i_value,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [1:0]                            o_status,
    output logic signed [sbms_pkg::VALUE_W-1:0]   o_popped
);

    sbms_pkg::t_cmd w_cmd;

    sbms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    sbms_datapath #(
        .NUM_STACKS (NUM_STACKS),
        .DEPTH      (DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_kind     (i_kind),
        .i_stack_id (i_stack_id),
        .i_value    (i_value),
        .o_status   (o_status),
        .o_popped   (o_popped)
    );

endmodule

// ===== src/sbms_ctrl.sv =====
`include "shared_buffer_multi_stack_defines.svh"

module sbms_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_stall,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output sbms_pkg::t_cmd    o_cmd
);

    sbms_pkg::t_state r_state;
    sbms_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sbms_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        o_in_stall   = 1'b1;
        n_out_valid  = r_out_valid && i_out_stall;
        case (r_state)
            sbms_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = sbms_pkg::ST_EXEC;
                end
            end
            sbms_pkg::ST_EXEC: begin
                // The update is held back until the result register can take the result.
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = sbms_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sbms_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    `SBMS_ASSERT_NEXT(a_load_enters_exec, i_clk, i_rst_n, o_cmd.load, r_state == sbms_pkg::ST_EXEC)
    `SBMS_ASSERT_NEXT(a_commit_shows_result, i_clk, i_rst_n, o_cmd.commit, o_out_valid && (r_state == sbms_pkg::ST_IDLE))
    `SBMS_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, o_cmd.commit, !(r_out_valid && i_out_stall))

endmodule

// ===== src/sbms_datapath.sv =====
`include "shared_buffer_multi_stack_defines.svh"

module sbms_datapath #(
    parameter int NUM_STACKS = 4,
    parameter int DEPTH      = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  sbms_pkg::t_cmd                        i_cmd,
    input  logic                                  i_kind,
    input  logic [sbms_pkg::SID_W-1:0]            i_stack_id,
    input  logic signed [sbms_pkg::VALUE_W-1:0]   i_value,
    output logic [1:0]                            o_status,
    output logic signed [sbms_pkg::VALUE_W-1:0]   o_popped
);

    localparam int IW   = $clog2(DEPTH);
    localparam int LW   = $clog2(DEPTH + 1);
    localparam int SIDW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam logic [LW-1:0] LINK_NONE = LW'(DEPTH);

    logic [sbms_pkg::VALUE_W-1:0] entry_data [DEPTH];
    logic [LW-1:0]                entry_link [DEPTH];

    logic [LW-1:0] r_stack_top [NUM_STACKS];
    logic [LW-1:0] r_free_head;
    // Entries at or above the fill mark have never been used, so their link is implicit.
    logic [LW-1:0] r_fill;

    logic                                r_kind;
    logic [sbms_pkg::SID_W-1:0]          r_sid;
    logic [sbms_pkg::VALUE_W-1:0]        r_value;
    logic [LW-1:0]                       r_top;
    logic [LW-1:0]                       r_link_rd;
    logic [sbms_pkg::VALUE_W-1:0]        r_data_rd;
    logic [1:0]                          r_status;
    logic signed [sbms_pkg::VALUE_W-1:0] r_popped;

    logic [SIDW-1:0] w_in_sel;
    logic [SIDW-1:0] w_sel;
    logic [LW-1:0]   w_top_in;
    logic [IW-1:0]   w_link_raddr;
    logic            w_sid_ok;
    logic            w_push_ok;
    logic            w_pop_ok;
    logic            w_head_fresh;
    logic [LW-1:0]   w_next_free;
    logic [IW-1:0]   w_wr_addr;
    logic [LW-1:0]   w_link_wdata;

    assign w_in_sel     = SIDW'(i_stack_id);
    assign w_sel        = SIDW'(r_sid);
    assign w_top_in     = r_stack_top[w_in_sel];
    assign w_link_raddr = (i_kind == sbms_pkg::KIND_PUSH) ? r_free_head[IW-1:0]
                                                          : w_top_in[IW-1:0];

    assign w_sid_ok     = (32'(r_sid) < 32'(NUM_STACKS));
    assign w_push_ok    = (r_kind == sbms_pkg::KIND_PUSH) && w_sid_ok
                          && (r_free_head != LINK_NONE);
    assign w_pop_ok     = (r_kind == sbms_pkg::KIND_POP) && w_sid_ok && (r_top != LINK_NONE);
    assign w_head_fresh = (r_free_head == r_fill);
    assign w_next_free  = w_head_fresh ? (r_free_head + LW'(1)) : r_link_rd;
    assign w_wr_addr    = w_push_ok ? r_free_head[IW-1:0] : r_top[IW-1:0];
    assign w_link_wdata = w_push_ok ? r_top : r_free_head;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_data_rd <= entry_data[w_top_in[IW-1:0]];
        end
        if (i_cmd.commit && w_push_ok) begin
            entry_data[r_free_head[IW-1:0]] <= r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_link_rd <= entry_link[w_link_raddr];
        end
        if (i_cmd.commit && (w_push_ok || w_pop_ok)) begin
            entry_link[w_wr_addr] <= w_link_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_sid   <= i_stack_id;
            r_value <= i_value;
            r_top   <= w_top_in;
        end
        if (i_cmd.commit) begin
            if (w_push_ok || w_pop_ok) begin
                r_status <= sbms_pkg::STATUS_DONE;
            end else if (r_kind == sbms_pkg::KIND_PUSH) begin
                r_status <= sbms_pkg::STATUS_FULL;
            end else begin
                r_status <= sbms_pkg::STATUS_EMPTY;
            end
            if (w_pop_ok) begin
                r_popped <= r_data_rd;
            end else if (r_kind == sbms_pkg::KIND_POP) begin
                r_popped <= sbms_pkg::POP_EMPTY_VALUE;
            end else begin
                r_popped <= sbms_pkg::PUSH_VALUE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_STACKS; s++) begin
                r_stack_top[s] <= LINK_NONE;
            end
            r_free_head <= '0;
            r_fill      <= '0;
        end else if (i_cmd.commit) begin
            if (w_push_ok) begin
                r_stack_top[w_sel] <= r_free_head;
                r_free_head        <= w_next_free;
                if (w_head_fresh) begin
                    r_fill <= r_fill + LW'(1);
                end
            end else if (w_pop_ok) begin
                r_stack_top[w_sel] <= r_link_rd;
                r_free_head        <= r_top;
            end
        end
    end

    assign o_status = r_status;
    assign o_popped = r_popped;

    `SBMS_ASSERT_SAME(a_head_within_fill, i_clk, i_rst_n, r_free_head != LINK_NONE, r_free_head <= r_fill)
    `SBMS_ASSERT_NEXT(a_fresh_push_fills, i_clk, i_rst_n, i_cmd.commit && w_push_ok && w_head_fresh, r_fill == $past(r_fill) + LW'(1))

endmodule

// ===== tb/tb.sv =====
module tb;

    localparam int N_STACKS    = 4;
    localparam int N_ENTRIES   = 16;
    localparam int MAX_REPORTS = 10;
    localparam logic [4:0] NO_ENTRY = 5'(N_ENTRIES);

    typedef struct packed {
        sbms_pkg::t_status                   status;
        logic signed [sbms_pkg::VALUE_W-1:0] popped;
    } t_reply;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_stall;
    logic                                i_kind = sbms_pkg::KIND_PUSH;
    logic [sbms_pkg::SID_W-1:0]          i_stack_id = '0;
    logic signed [sbms_pkg::VALUE_W-1:0] i_value = '0;
    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    logic [1:0]                          o_status;
    logic signed [sbms_pkg::VALUE_W-1:0] o_popped;

    // Shadow copy of the linked entry store.
    logic [sbms_pkg::VALUE_W-1:0] slot_value [N_ENTRIES];
    logic [4:0]                   slot_next [N_ENTRIES];
    logic [4:0]                   top_slot [N_STACKS];
    logic [4:0]                   free_slot;

    t_reply reply_q [$];
    int     send_idle_pct = 0;
    int     out_stall_pct = 0;
    int     mismatches = 0;

    shared_buffer_multi_stack #(
        .NUM_STACKS(N_STACKS),
        .DEPTH     (N_ENTRIES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_kind     (i_kind),
        .i_stack_id (i_stack_id),
        .i_value    (i_value),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_status   (o_status),
        .o_popped   (o_popped)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void stack_store_reset();
        for (int i = 0; i < N_ENTRIES; i++) begin
            slot_value[i] = '0;
            slot_next[i]  = 5'(i + 1);
        end
        for (int s = 0; s < N_STACKS; s++) begin
            top_slot[s] = NO_ENTRY;
        end
        free_slot = '0;
    endfunction

    // Every stack_id that fits in the field names a stack, so only the free list
    // and the stack tops decide between done, full and empty.
    function automatic t_reply stack_store_apply(input sbms_pkg::t_kind k,
                                                 input logic [sbms_pkg::SID_W-1:0] sid,
                                                 input logic [sbms_pkg::VALUE_W-1:0] v);
        t_reply     r;
        logic [4:0] idx;
        if (k == sbms_pkg::KIND_PUSH) begin
            r.popped = sbms_pkg::PUSH_VALUE;
            if (free_slot >= NO_ENTRY) begin
                r.status = sbms_pkg::STATUS_FULL;
            end else begin
                idx             = free_slot;
                slot_value[idx] = v;
                free_slot       = slot_next[idx];
                slot_next[idx]  = top_slot[sid];
                top_slot[sid]   = idx;
                r.status        = sbms_pkg::STATUS_DONE;
            end
        end else if (top_slot[sid] >= NO_ENTRY) begin
            r.status = sbms_pkg::STATUS_EMPTY;
            r.popped = sbms_pkg::POP_EMPTY_VALUE;
        end else begin
            idx            = top_slot[sid];
            top_slot[sid]  = slot_next[idx];
            slot_next[idx] = free_slot;
            free_slot      = idx;
            r.status       = sbms_pkg::STATUS_DONE;
            r.popped       = slot_value[idx];
        end
        return r;
    endfunction

    function automatic void note_mismatch(input string what,
                                          input logic [sbms_pkg::VALUE_W-1:0] want,
                                          input logic [sbms_pkg::VALUE_W-1:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t: %s: expected %0h, got %0h", $time, what, want, got);
        end
    endfunction

    task automatic send_op(input sbms_pkg::t_kind k, input logic [sbms_pkg::SID_W-1:0] sid,
                           input logic [sbms_pkg::VALUE_W-1:0] v);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= k;
        i_stack_id <= sid;
        i_value    <= v;
        do @(posedge i_clk); while (o_in_stall);
        reply_q.push_back(stack_store_apply(k, sid, v));
    endtask

    task automatic wait_for_replies();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (reply_q.size() != 0) @(posedge i_clk);
    endtask

    // Outputs are sampled at the edge, before the block's own updates land.
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (reply_q.size() == 0) begin
                note_mismatch("result with nothing outstanding", '0, o_popped);
            end else begin
                want = reply_q.pop_front();
                if (o_status !== want.status)
                    note_mismatch("status", sbms_pkg::VALUE_W'(want.status),
                                  sbms_pkg::VALUE_W'(o_status));
                if (o_popped !== want.popped)
                    note_mismatch("popped value", want.popped, o_popped);
            end
        end
        i_out_stall <= ($urandom_range(99, 0) < out_stall_pct);
    end

    task automatic test_empty_pops();
        for (int s = 0; s < N_STACKS; s++) begin
            send_op(sbms_pkg::KIND_POP, sbms_pkg::SID_W'(s), $urandom);
        end
    endtask

    // Fill the whole store across all stacks, try one push too many, then pop
    // each stack once.
    task automatic test_fill_and_refuse();
        logic [sbms_pkg::VALUE_W-1:0] patterns [8];
        patterns = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
                     32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001, 32'hffff_fffe};
        for (int i = 0; i < N_ENTRIES; i++) begin
            send_op(sbms_pkg::KIND_PUSH, sbms_pkg::SID_W'(i % N_STACKS),
                    (i < 8) ? patterns[i] : $urandom);
        end
        send_op(sbms_pkg::KIND_PUSH, sbms_pkg::SID_W'(2), 32'h1234_5678);
        for (int s = 0; s < N_STACKS; s++) begin
            send_op(sbms_pkg::KIND_POP, sbms_pkg::SID_W'(s), $urandom);
        end
    endtask

    // Bursts lean towards pushes or pops, or mix them evenly, so that the store keeps running full
    // and stacks keep running dry.
    task automatic test_random_traffic(input int n_ops, input int idle_pct, input int stall_pct);
        int                           sent;
        int                           burst_len;
        int                           push_pct;
        logic [sbms_pkg::SID_W-1:0]   focus;
        logic [sbms_pkg::SID_W-1:0]   sid;
        logic [sbms_pkg::VALUE_W-1:0] v;
        sbms_pkg::t_kind              k;
        send_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_ops) begin
            burst_len = $urandom_range(40, 6);
            focus     = sbms_pkg::SID_W'($urandom_range(N_STACKS - 1, 0));
            case ($urandom_range(2, 0))
                0: push_pct = 20;
                1: push_pct = 50;
                default: push_pct = 85;
            endcase
            for (int i = 0; i < burst_len && sent < n_ops; i++) begin
                k   = ($urandom_range(99, 0) < push_pct) ? sbms_pkg::KIND_PUSH
                                                         : sbms_pkg::KIND_POP;
                sid = $urandom_range(1, 0) ? focus
                                           : sbms_pkg::SID_W'($urandom_range(N_STACKS - 1, 0));
                case ($urandom_range(15, 0))
                    0: v = 32'h7fff_ffff;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_0000;
                    3: v = 32'hffff_ffff;
                    default: v = $urandom;
                endcase
                send_op(k, sid, v);
                sent++;
            end
        end
        wait_for_replies();
    endtask

    initial begin
        stack_store_reset();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_pops();
        test_fill_and_refuse();
        wait_for_replies();
        test_random_traffic(240, 0, 0);
        test_random_traffic(240, 85, 0);
        test_random_traffic(240, 0, 85);
        test_random_traffic(230, 34, 34);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
